### sv/ttuv_pkg.sv
// Shared types and constants for the triangle tangent block.
`timescale 1ns / 1ps
package ttuv_pkg;
	localparam int PosW = 32;
	localparam int TexW = 24;
	localparam int TanW = 16;
	localparam int DpW = 33;
	localparam int DtW = 25;
	localparam int RawW = 60;
	localparam int MagW = 59;
	localparam int NrmW = 30;

	typedef struct packed {
		logic load_v0;
		logic load_v1;
		logic start;
		logic step;
	} ttuv_cmd_t;

	typedef struct packed {
		logic done;
	} ttuv_sts_t;
endpackage

### sv/ttuv_datapath.sv
// Datapath: vertex holding, cross terms, normalization, square root and division.
`timescale 1ns / 1ps
module ttuv_datapath (
	input  logic clk,
	input  ttuv_pkg::ttuv_cmd_t cmd,
	input  logic signed [ttuv_pkg::PosW-1:0] pos_x,
	input  logic signed [ttuv_pkg::PosW-1:0] pos_y,
	input  logic signed [ttuv_pkg::PosW-1:0] pos_z,
	input  logic signed [ttuv_pkg::TexW-1:0] tex_u,
	input  logic signed [ttuv_pkg::TexW-1:0] tex_v,
	output ttuv_pkg::ttuv_sts_t sts,
	output logic signed [ttuv_pkg::TanW-1:0] tan_x,
	output logic signed [ttuv_pkg::TanW-1:0] tan_y,
	output logic signed [ttuv_pkg::TanW-1:0] tan_z,
	output logic degenerate
);
	localparam int MW = ttuv_pkg::MagW;
	localparam int NW = ttuv_pkg::NrmW;

	typedef enum logic [2:0] {P_DELTA, P_MUL, P_RAW, P_NORM, P_SQ, P_ROOT, P_DIV, P_DONE}
		phase_t;

	logic signed [ttuv_pkg::PosW-1:0] p0_q [3];
	logic signed [ttuv_pkg::PosW-1:0] p1_q [3];
	logic signed [ttuv_pkg::PosW-1:0] p2_q [3];
	logic signed [ttuv_pkg::TexW-1:0] t0_q [2];
	logic signed [ttuv_pkg::TexW-1:0] t1_q [2];
	logic signed [ttuv_pkg::TexW-1:0] t2_q [2];

	phase_t ph_q;
	logic [1:0] idx_q;
	logic signed [ttuv_pkg::DpW-1:0] dp1_q [3];
	logic signed [ttuv_pkg::DpW-1:0] dp2_q [3];
	logic signed [ttuv_pkg::DtW-1:0] du1_q, dv1_q, du2_q, dv2_q;
	logic signed [ttuv_pkg::RawW-1:0] pa_q [3];
	logic signed [ttuv_pkg::RawW-1:0] pb_q [3];
	logic signed [50:0] da_q, db_q;
	logic signed [ttuv_pkg::RawW-1:0] raw_q [3];
	logic det_neg_q, det_zero_q;
	logic [MW-1:0] m_q [3];
	logic [NW-1:0] n_q [3];
	logic [63:0] sq_q, rem_q, root_q, bit_q;
	logic [NW:0] len_q;
	logic [NW+14:0] num_q, quo_q;
	logic [NW+14:0] div_q;
	logic [5:0] cnt_q;
	logic [ttuv_pkg::TanW-1:0] res_q [3];
	logic degen_q;

	logic [MW-1:0] big;
	logic [5:0] lead;
	logic [NW+14:0] trial;

	always_comb begin
		big = m_q[0] | m_q[1] | m_q[2];
		lead = '0;
		for (int i = 0; i < MW; i++) begin
			if (big[i]) lead = 6'(i);
		end
	end

	assign trial = {div_q[NW+13:0], num_q[NW+14]};

	always_ff @(posedge clk) begin
		if (cmd.load_v0) begin
			p0_q[0] <= pos_x; p0_q[1] <= pos_y; p0_q[2] <= pos_z;
			t0_q[0] <= tex_u; t0_q[1] <= tex_v;
		end
		if (cmd.load_v1) begin
			p1_q[0] <= pos_x; p1_q[1] <= pos_y; p1_q[2] <= pos_z;
			t1_q[0] <= tex_u; t1_q[1] <= tex_v;
		end
		if (cmd.start) begin
			p2_q[0] <= pos_x; p2_q[1] <= pos_y; p2_q[2] <= pos_z;
			t2_q[0] <= tex_u; t2_q[1] <= tex_v;
			ph_q <= P_DELTA;
			idx_q <= '0;
		end else if (cmd.step) begin
			unique case (ph_q)
				P_DELTA: begin
					for (int i = 0; i < 3; i++) begin
						dp1_q[i] <= 33'(p1_q[i]) - 33'(p0_q[i]);
						dp2_q[i] <= 33'(p2_q[i]) - 33'(p0_q[i]);
					end
					du1_q <= 25'(t1_q[0]) - 25'(t0_q[0]);
					dv1_q <= 25'(t1_q[1]) - 25'(t0_q[1]);
					du2_q <= 25'(t2_q[0]) - 25'(t0_q[0]);
					dv2_q <= 25'(t2_q[1]) - 25'(t0_q[1]);
					ph_q <= P_MUL;
				end
				P_MUL: begin
					for (int i = 0; i < 3; i++) begin
						pa_q[i] <= 60'(dv2_q * dp1_q[i]);
						pb_q[i] <= 60'(dv1_q * dp2_q[i]);
					end
					da_q <= 51'(du1_q * dv2_q);
					db_q <= 51'(du2_q * dv1_q);
					ph_q <= P_RAW;
				end
				P_RAW: begin
					for (int i = 0; i < 3; i++) begin
						raw_q[i] <= pa_q[i] - pb_q[i];
						m_q[i] <= (pa_q[i] - pb_q[i]) < 0 ? MW'(pb_q[i] - pa_q[i])
							: MW'(pa_q[i] - pb_q[i]);
					end
					det_neg_q <= da_q < db_q;
					det_zero_q <= da_q == db_q;
					ph_q <= P_NORM;
				end
				P_NORM: begin
					degen_q <= det_zero_q || big == '0;
					for (int i = 0; i < 3; i++) begin
						if (lead >= 6'd29) n_q[i] <= NW'(m_q[i] >> (lead - 6'd29));
						else n_q[i] <= NW'(m_q[i] << (6'd29 - lead));
					end
					idx_q <= '0;
					sq_q <= '0;
					ph_q <= P_SQ;
				end
				P_SQ: begin
					sq_q <= sq_q + 64'(n_q[idx_q] * n_q[idx_q]);
					if (idx_q == 2'd2) begin
						ph_q <= P_ROOT;
						bit_q <= 64'd1 << 62;
						root_q <= '0;
					end
					idx_q <= idx_q + 2'd1;
				end
				P_ROOT: begin
					if (bit_q == '0) begin
						len_q <= (root_q == '0) ? (NW+1)'(1) : (NW+1)'(root_q);
						idx_q <= '0;
						cnt_q <= '0;
						div_q <= '0;
						num_q <= {1'b0, n_q[0], 14'd0} + (NW+15)'(root_q >> 1);
						quo_q <= '0;
						ph_q <= P_DIV;
					end else begin
						if (rem_q >= root_q + bit_q) begin
							rem_q <= rem_q - (root_q + bit_q);
							root_q <= (root_q >> 1) + bit_q;
						end else begin
							root_q <= root_q >> 1;
						end
						bit_q <= bit_q >> 2;
					end
				end
				P_DIV: begin
					if (cnt_q == 6'(NW+15)) begin
						res_q[idx_q] <= ((quo_q > 16384 ? 16'd16384 : 16'(quo_q))
							^ {16{raw_q[idx_q] < 0 != det_neg_q}})
							+ 16'(raw_q[idx_q] < 0 != det_neg_q);
						cnt_q <= '0;
						div_q <= '0;
						quo_q <= '0;
						if (idx_q == 2'd2) ph_q <= P_DONE;
						else num_q <= {1'b0, n_q[idx_q + 2'd1], 14'd0}
							+ (NW+15)'(len_q >> 1);
						idx_q <= idx_q + 2'd1;
					end else begin
						if (trial >= (NW+15)'(len_q)) begin
							div_q <= trial - (NW+15)'(len_q);
							quo_q <= {quo_q[NW+13:0], 1'b1};
						end else begin
							div_q <= trial;
							quo_q <= {quo_q[NW+13:0], 1'b0};
						end
						num_q <= num_q << 1;
						cnt_q <= cnt_q + 6'd1;
					end
				end
				P_DONE: ;
				default: ;
			endcase
			if (ph_q == P_SQ && idx_q == 2'd2)
				rem_q <= sq_q + 64'(n_q[2] * n_q[2]);
		end
	end

	assign sts.done = ph_q == P_DONE;
	assign tan_x = degen_q ? '0 : res_q[0];
	assign tan_y = degen_q ? '0 : res_q[1];
	assign tan_z = degen_q ? '0 : res_q[2];
	assign degenerate = degen_q;
endmodule

### sv/ttuv_ctrl.sv
// Controller: vertex phase, compute sequencing and result repetition.
`timescale 1ns / 1ps
module ttuv_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output logic last_copy,
	output ttuv_pkg::ttuv_cmd_t cmd,
	input  ttuv_pkg::ttuv_sts_t sts
);
	typedef enum logic [1:0] {S_TAKE, S_CALC, S_EMIT} state_t;
	state_t state_q;
	logic [1:0] phase_q, copy_q;
	logic take;

	assign in_ready = state_q == S_TAKE;
	assign take = in_valid && in_ready;
	assign out_valid = state_q == S_EMIT;
	assign last_copy = copy_q == 2'd2;

	always_comb begin
		cmd = '0;
		cmd.load_v0 = take && phase_q != 2'd1 && phase_q != 2'd2;
		cmd.load_v1 = take && phase_q == 2'd1;
		cmd.start = take && phase_q == 2'd2;
		cmd.step = state_q == S_CALC;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_TAKE;
			phase_q <= '0;
			copy_q <= '0;
		end else begin
			unique case (state_q)
				S_TAKE: if (take) begin
					if (phase_q == 2'd2) begin
						phase_q <= '0;
						state_q <= S_CALC;
					end else begin
						phase_q <= (phase_q == 2'd1) ? 2'd2 : 2'd1;
					end
				end
				S_CALC: if (sts.done) begin
					copy_q <= '0;
					state_q <= S_EMIT;
				end
				S_EMIT: if (out_ready) begin
					copy_q <= copy_q + 2'd1;
					if (copy_q == 2'd2) state_q <= S_TAKE;
				end
				default: state_q <= S_TAKE;
			endcase
		end
	end
endmodule

### sv/triangle_tangent_from_uv_core.sv
// Top level of the per-triangle tangent block.
// Vertices are taken one per transaction; the first two of a triangle are held in
// registers. The third starts a sequence: deltas, products, raw tangent and
// normalization, a sum of squares over the three components, a bit-pair square root,
// three restoring divisions in one shared divider, and a hand-over. The unit tangent
// is then delivered three times, the third copy marked by last_copy, and no new vertex
// is taken until the third copy is accepted; a zero determinant or zero vector gives
// degenerate with a zero tangent.
`timescale 1ns / 1ps
module triangle_tangent_from_uv_core (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [23:0] tex_u,
	input  logic signed [23:0] tex_v,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [15:0] tan_x,
	output logic signed [15:0] tan_y,
	output logic signed [15:0] tan_z,
	output logic degenerate,
	output logic last_copy
);
	ttuv_pkg::ttuv_cmd_t cmd;
	ttuv_pkg::ttuv_sts_t sts;

	ttuv_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
		.last_copy, .cmd, .sts
	);

	ttuv_datapath u_dp (
		.clk, .cmd, .pos_x, .pos_y, .pos_z, .tex_u, .tex_v, .sts,
		.tan_x, .tan_y, .tan_z, .degenerate
	);
endmodule
